// ===== sv/tea_pkg.sv =====
// Shared types, constants and the round mixing function of the TEA block cipher.
// Used by every module of the block. Has no dependencies of its own.
package tea_pkg;

   // Number of full cipher cycles (each is two half-round cells).
   localparam int TEA_ROUND_COUNT = 32;

   // Round constant of the cipher.
   localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

   // Key registers after reset, and the register indexes.
   localparam int TEA_KEY_WORDS = 4;
   localparam logic [31:0] TEA_KEY_RESET_0 = 32'hB0F6_FE55;
   localparam logic [31:0] TEA_KEY_RESET_1 = 32'h410B_BF62;
   localparam logic [31:0] TEA_KEY_RESET_2 = 32'hB47C_B3C9;
   localparam logic [31:0] TEA_KEY_RESET_3 = 32'h7B29_3E97;

   localparam int TEA_CSR_INDEX_W = 8;
   localparam logic [TEA_CSR_INDEX_W-1:0] TEA_CSR_KEY_WORD_0 = 8'd0;
   localparam logic [TEA_CSR_INDEX_W-1:0] TEA_CSR_KEY_WORD_1 = 8'd1;
   localparam logic [TEA_CSR_INDEX_W-1:0] TEA_CSR_KEY_WORD_2 = 8'd2;
   localparam logic [TEA_CSR_INDEX_W-1:0] TEA_CSR_KEY_WORD_3 = 8'd3;

   // Operation codes carried in the mode bit.
   localparam logic TEA_MODE_ENCRYPT = 1'b0;
   localparam logic TEA_MODE_DECRYPT = 1'b1;

   // The 128-bit key as four words.
   typedef logic [TEA_KEY_WORDS-1:0][31:0] tea_key_type;

   // Input transaction payload.
   typedef struct packed {
      logic        mode;
      logic [31:0] first_word;
      logic [31:0] second_word;
   } tea_req_type;

   // Result transaction payload.
   typedef struct packed {
      logic [31:0] first_word_out;
      logic [31:0] second_word_out;
   } tea_rsp_type;

   // Block in flight between two cells.
   typedef struct packed {
      logic        mode;
      logic [31:0] word_a;
      logic [31:0] word_b;
   } tea_blk_type;

   // One stage of the cell chain: a valid flag and its block.
   typedef struct packed {
      logic        valid;
      tea_blk_type blk;
   } tea_stage_type;

   // Feistel mixing of one word with the running sum and two key words.
   function automatic logic [31:0] tea_mix(input logic [31:0] w,
                                           input logic [31:0] sum,
                                           input logic [31:0] ka,
                                           input logic [31:0] kb);
      return ((w << 4) + ka) ^ (w + sum) ^ ((w >> 5) + kb);
   endfunction

endpackage

// ===== sv/tea_block_cipher_top.sv =====
// Top level of the TEA block cipher: key registers, the cell chain and output buffer.
// Depends on tea_pkg, tea_cell and tea_out_buf.
// A result passes 2*ROUND_COUNT cell registers and the output register before it is presented.
// Throughput: one transaction per cycle while req_stall is low; each half-round is one cell of the chain.
// req_stall rises only while the skid stage holds a result behind a pending output result.
// Reset is synchronous: it empties the chain and loads the default key.
module tea_block_cipher_top
   import tea_pkg::*;
#(
   parameter int ROUND_COUNT = TEA_ROUND_COUNT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  tea_req_type                req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output tea_rsp_type                rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [TEA_CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                csr_data
);

   localparam int CELL_COUNT = 2 * ROUND_COUNT;

   tea_key_type   key_ff;
   tea_stage_type chain [CELL_COUNT+1];
   logic          advance;

   // Key registers take a write in any cycle; unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff[0] <= TEA_KEY_RESET_0;
         key_ff[1] <= TEA_KEY_RESET_1;
         key_ff[2] <= TEA_KEY_RESET_2;
         key_ff[3] <= TEA_KEY_RESET_3;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            TEA_CSR_KEY_WORD_0: key_ff[0] <= csr_data;
            TEA_CSR_KEY_WORD_1: key_ff[1] <= csr_data;
            TEA_CSR_KEY_WORD_2: key_ff[2] <= csr_data;
            TEA_CSR_KEY_WORD_3: key_ff[3] <= csr_data;
            default: ;
         endcase
      end
   end

   // Head of the chain is the incoming transaction.
   assign req_stall         = !advance;
   assign chain[0].valid    = req_valid;
   assign chain[0].blk.mode   = req_data.mode;
   assign chain[0].blk.word_a = req_data.first_word;
   assign chain[0].blk.word_b = req_data.second_word;

   // Each cell carries its round's sum, shared by the two cells of a round, fixed at elaboration.
   for (genvar c = 0; c < CELL_COUNT; c++) begin : g_cell
      localparam int          ROUND   = c / 2;
      localparam logic [63:0] ENC_W   = 64'(TEA_DELTA) * 64'(ROUND + 1);
      localparam logic [63:0] DEC_W   = 64'(TEA_DELTA) * 64'(ROUND_COUNT - ROUND);
      tea_cell #(
         .SECOND_HALF (1'((c % 2) == 1)),
         .SUM_ENC     (ENC_W[31:0]),
         .SUM_DEC     (DEC_W[31:0])
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .key       (key_ff),
         .stage_in  (chain[c]),
         .stage_out (chain[c+1])
      );
   end

   // Output register and skid stage.
   tea_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .chain_out (chain[CELL_COUNT]),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // An accepted transaction enters the first cell.
   accept_enters_chain: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> chain[1].valid)
      else $error("accepted transaction missing from first cell");

   // The last cell of the chain holds its contents while stalled.
   chain_holds: assert property (@(posedge clock) disable iff (reset)
      req_stall |=> $stable(chain[CELL_COUNT]))
      else $error("chain moved while held");

   // Writes to unknown indexes leave the key alone.
   csr_unknown_ignored: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready && (csr_index > TEA_CSR_KEY_WORD_3)) |=> $stable(key_ff))
      else $error("key changed by a write to an unknown index");

endmodule

// ===== sv/tea_cell.sv =====
// One half-round cell of the TEA cell chain: updates one word of the block.
// Depends on tea_pkg for the block types and the mixing function.
module tea_cell
   import tea_pkg::*;
#(
   parameter bit          SECOND_HALF = 1'b0,
   parameter logic [31:0] SUM_ENC     = 32'h0,
   parameter logic [31:0] SUM_DEC     = 32'h0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  tea_key_type   key,
   input  tea_stage_type stage_in,
   output tea_stage_type stage_out
);

   logic        valid_ff;
   tea_blk_type blk_ff;
   tea_blk_type blk_in;

   logic        decrypt;
   logic        upd_b;
   logic [31:0] mix_src;
   logic [31:0] mix_sum;
   logic [31:0] mix_ka;
   logic [31:0] mix_kb;
   logic [31:0] mix_val;

   // Encryption updates word a then word b; decryption goes b then a.
   always_comb begin
      decrypt = (stage_in.blk.mode == TEA_MODE_DECRYPT);
      upd_b   = decrypt ^ SECOND_HALF;
      mix_src = upd_b ? stage_in.blk.word_a : stage_in.blk.word_b;
      mix_ka  = upd_b ? key[2] : key[0];
      mix_kb  = upd_b ? key[3] : key[1];
      mix_sum = decrypt ? SUM_DEC : SUM_ENC;
      mix_val = tea_mix(mix_src, mix_sum, mix_ka, mix_kb);
      blk_in  = stage_in.blk;
      if (upd_b) begin
         blk_in.word_b = decrypt ? stage_in.blk.word_b - mix_val
                                 : stage_in.blk.word_b + mix_val;
      end else begin
         blk_in.word_a = decrypt ? stage_in.blk.word_a - mix_val
                                 : stage_in.blk.word_a + mix_val;
      end
   end

   // Stage register; the whole chain moves together on advance.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_in.valid;
      end
      if (advance) begin
         blk_ff <= blk_in;
      end
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.blk   = blk_ff;

endmodule

// ===== sv/tea_out_buf.sv =====
// Output register with a skid stage at the end of the TEA cell chain.
// Depends on tea_pkg for the stage and result types.
module tea_out_buf
   import tea_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  tea_stage_type chain_out,
   output logic          advance,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output tea_rsp_type   rsp_data
);

   logic        rsp_valid_ff;
   tea_blk_type rsp_blk_ff;
   logic        skid_valid_ff;
   tea_blk_type skid_blk_ff;
   logic        out_taken;
   logic        chain_push;

   // The chain holds only while the skid stage is occupied.
   assign advance    = !skid_valid_ff;
   assign out_taken  = rsp_valid_ff && !rsp_stall;
   assign chain_push = advance && chain_out.valid;

   // Result register is filled from the skid stage first, then from the chain.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (skid_valid_ff) begin
            if (out_taken) begin
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end
         end else if (chain_push) begin
            if (!rsp_valid_ff || out_taken) begin
               rsp_valid_ff <= 1'b1;
            end else begin
               skid_valid_ff <= 1'b1;
            end
         end else if (out_taken) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (skid_valid_ff) begin
         if (out_taken) begin
            rsp_blk_ff <= skid_blk_ff;
         end
      end else if (chain_push) begin
         if (!rsp_valid_ff || out_taken) begin
            rsp_blk_ff <= chain_out.blk;
         end else begin
            skid_blk_ff <= chain_out.blk;
         end
      end
   end

   assign rsp_valid                = rsp_valid_ff;
   assign rsp_data.first_word_out  = rsp_blk_ff.word_a;
   assign rsp_data.second_word_out = rsp_blk_ff.word_b;

   // The skid stage is only used behind a held result.
   skid_behind_result: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid stage occupied without a pending result");

   // A chain result arriving while the output is held must land in the skid stage.
   chain_into_skid: assert property (@(posedge clock) disable iff (reset)
      (chain_push && rsp_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("chain result lost behind a held output");

   // A drained skid stage reloads the result register.
   skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (rsp_valid_ff && !skid_valid_ff))
      else $error("skid stage did not drain into the result register");

endmodule

// ===== verif/tea_block_cipher_top_tb.sv =====
// Self-checking testbench for tea_block_cipher_top: encrypts and decrypts blocks under several
// keys and compares each result with a cipher computed in the bench itself.
// Depends on tea_pkg and tea_block_cipher_top.
module tea_block_cipher_top_tb;
   import tea_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int CHAIN_LATENCY = 2 * TEA_ROUND_COUNT + 1;
   localparam int BLOCKS_PER_PHASE = 275;
   localparam int KEY_PHASES = 6;
   localparam logic [TEA_CSR_INDEX_W-1:0] CSR_UNUSED_FIRST = TEA_CSR_INDEX_W'(TEA_KEY_WORDS);
   localparam logic [TEA_CSR_INDEX_W-1:0] CSR_UNUSED_LAST = '1;

   // Tracks the key, computes the cipher of every accepted block and checks the results.
   class tea_cipher_ledger;
      tea_key_type key;
      tea_rsp_type awaited[$];
      int unsigned failures;
      int unsigned blocks_seen;
      int unsigned decrypts_seen;

      function new();
         key = {TEA_KEY_RESET_3, TEA_KEY_RESET_2, TEA_KEY_RESET_1, TEA_KEY_RESET_0};
      endfunction

      // Writes to an index past the last key word leave the key as it is.
      function void set_key(logic [TEA_CSR_INDEX_W-1:0] index, logic [31:0] value);
         case (index)
            TEA_CSR_KEY_WORD_0: key[0] = value;
            TEA_CSR_KEY_WORD_1: key[1] = value;
            TEA_CSR_KEY_WORD_2: key[2] = value;
            TEA_CSR_KEY_WORD_3: key[3] = value;
            default: ;
         endcase
      endfunction

      function logic [31:0] round_mix(logic [31:0] w, logic [31:0] s,
                                      logic [31:0] ka, logic [31:0] kb);
         logic [31:0] shifted_up;
         logic [31:0] shifted_down;
         shifted_up = (w << 4) + ka;
         shifted_down = (w >> 5) + kb;
         return shifted_up ^ (w + s) ^ shifted_down;
      endfunction

      // Full TEA transform of one block under the current key.
      function tea_rsp_type cipher_block(tea_req_type blk);
         logic [31:0] a;
         logic [31:0] b;
         logic [31:0] s;
         tea_rsp_type res;
         a = blk.first_word;
         b = blk.second_word;
         if (blk.mode == TEA_MODE_DECRYPT) begin
            s = TEA_DELTA * TEA_ROUND_COUNT;
            for (int r = 0; r < TEA_ROUND_COUNT; r++) begin
               b = b - round_mix(a, s, key[2], key[3]);
               a = a - round_mix(b, s, key[0], key[1]);
               s = s - TEA_DELTA;
            end
         end else begin
            s = '0;
            for (int r = 0; r < TEA_ROUND_COUNT; r++) begin
               s = s + TEA_DELTA;
               a = a + round_mix(b, s, key[0], key[1]);
               b = b + round_mix(a, s, key[2], key[3]);
            end
         end
         res.first_word_out = a;
         res.second_word_out = b;
         return res;
      endfunction

      // Called for each accepted input transaction; returns the awaited result.
      function tea_rsp_type note_block(tea_req_type blk);
         tea_rsp_type res;
         res = cipher_block(blk);
         awaited = {awaited, res};
         blocks_seen++;
         if (blk.mode == TEA_MODE_DECRYPT) begin
            decrypts_seen++;
         end
         return res;
      endfunction

      // Called for each accepted result transaction.
      function void check_block(tea_rsp_type got);
         tea_rsp_type want;
         if (awaited.size() == 0) begin
            $error("result %h arrived with no block outstanding", got);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (got.first_word_out !== want.first_word_out) begin
            $error("first_word_out expected %h actual %h",
                   want.first_word_out, got.first_word_out);
            failures++;
         end
         if (got.second_word_out !== want.second_word_out) begin
            $error("second_word_out expected %h actual %h",
                   want.second_word_out, got.second_word_out);
            failures++;
         end
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   tea_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   tea_rsp_type rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [TEA_CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   tea_cipher_ledger ledger;
   tea_req_type      round_trips[$];
   int               send_idle_pct = 0;
   int               rsp_idle_pct = 0;
   logic             quiet_stretch = 1'b0;
   int unsigned      cycle_count = 0;
   int unsigned      keys_used = 1;

   tea_block_cipher_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[tea_block_cipher_top] ERROR");
         $finish;
      end
   end

   // Result side: check each accepted transaction, then choose the next stall.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         ledger.check_block(rsp_data);
      end
      rsp_stall <= !quiet_stretch && ($urandom_range(99, 0) < rsp_idle_pct);
   end

   // Words that favor the edges of the range now and then.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(9, 0))
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(31, 0);
         3: return ~(32'h1 << $urandom_range(31, 0));
         default: return $urandom();
      endcase
   endfunction

   // Offers one block, with random idle cycles first, and waits until it is taken.
   task automatic send_block(input tea_req_type blk);
      tea_rsp_type res;
      tea_req_type inverse;
      while (!quiet_stretch && ($urandom_range(99, 0) < send_idle_pct)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= blk;
      do @(posedge clock); while (req_stall);
      res = ledger.note_block(blk);
      // Remember the inverse transaction so that a later block can undo this one.
      inverse.mode = !blk.mode;
      inverse.first_word = res.first_word_out;
      inverse.second_word = res.second_word_out;
      round_trips = {round_trips, inverse};
      if (round_trips.size() > 16) begin
         void'(round_trips.pop_front());
      end
   endtask

   // One register write; the caller lowers csr_valid after its last write.
   task automatic write_csr(input logic [TEA_CSR_INDEX_W-1:0] index, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      ledger.set_key(index, value);
   endtask

   task automatic load_key(input tea_key_type k);
      write_csr(TEA_CSR_KEY_WORD_0, k[0]);
      write_csr(TEA_CSR_KEY_WORD_1, k[1]);
      write_csr(TEA_CSR_KEY_WORD_2, k[2]);
      write_csr(TEA_CSR_KEY_WORD_3, k[3]);
      csr_valid <= 1'b0;
      keys_used++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   // Main sequence.
   initial begin
      logic [31:0] edge_words[6];
      tea_key_type key_plan[KEY_PHASES];
      tea_req_type blk;

      ledger = new();
      edge_words = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000,
                     32'h0000_0001, 32'hAAAA_AAAA, 32'h5555_5555};
      key_plan[0] = '0;
      key_plan[1] = '1;
      key_plan[2] = {$urandom(), $urandom(), $urandom(), $urandom()};
      key_plan[3] = {TEA_KEY_RESET_3, TEA_KEY_RESET_2, TEA_KEY_RESET_1, TEA_KEY_RESET_0};
      key_plan[4] = {32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA};
      key_plan[5] = {$urandom(), $urandom(), $urandom(), $urandom()};

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Writes past the last key word must not disturb the reset key.
      write_csr(CSR_UNUSED_FIRST, $urandom());
      write_csr(CSR_UNUSED_LAST, $urandom());
      csr_valid <= 1'b0;

      // Directed blocks: edge patterns in both modes under the reset key.
      send_idle_pct = 29;
      rsp_idle_pct = 61;
      for (int m = 0; m < 2; m++) begin
         for (int i = 0; i < 6; i++) begin
            blk.mode = m[0];
            blk.first_word = edge_words[i];
            blk.second_word = edge_words[5 - i];
            send_block(blk);
         end
         blk.first_word = '0;
         blk.second_word = '0;
         send_block(blk);
         blk.first_word = '1;
         blk.second_word = '1;
         send_block(blk);
      end
      // Encrypt then decrypt, and decrypt then encrypt, of random blocks.
      for (int m = 0; m < 2; m++) begin
         blk.mode = m[0];
         blk.first_word = $urandom();
         blk.second_word = $urandom();
         send_block(blk);
         send_block(round_trips[$]);
      end

      // Random phases, each under its own key and one of three flow-control profiles.
      for (int p = 0; p < KEY_PHASES; p++) begin
         drain();
         load_key(key_plan[p]);
         round_trips.delete();
         case (p % 3)
            0: begin
               send_idle_pct = 29;
               rsp_idle_pct = 61;
            end
            1: begin
               send_idle_pct = 61;
               rsp_idle_pct = 29;
            end
            default: begin
               send_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < BLOCKS_PER_PHASE; n++) begin
            if (n % 50 == 0) begin
               quiet_stretch <= ($urandom_range(3, 0) == 0);
            end
            if (round_trips.size() != 0 && $urandom_range(9, 0) < 3) begin
               blk = round_trips[$urandom_range(round_trips.size() - 1, 0)];
            end else begin
               blk.mode = 1'($urandom_range(1, 0));
               blk.first_word = pick_word();
               blk.second_word = pick_word();
            end
            send_block(blk);
         end
      end

      // Wrap up once every result is in and the chain has had time to flush.
      drain();
      quiet_stretch <= 1'b0;
      repeat (CHAIN_LATENCY + 8) @(posedge clock);
      $display("Covered %0d blocks (%0d decrypted) under %0d keys, reset, zero and one keys",
               ledger.blocks_seen, ledger.decrypts_seen, keys_used);
      $display("among them; edge words, round trips and three flow-control profiles used.");
      if (ledger.failures == 0 && ledger.pending() == 0) begin
         $display("[tea_block_cipher_top] OK");
      end else begin
         $display("[tea_block_cipher_top] ERROR");
      end
      $finish;
   end

endmodule
